// ----- hdl/time_ordered_insert_queue_unit_defines.svh -----
// ----------------------------------------------------------------------------
// time_ordered_insert_queue_unit_defines.svh
// Assertion macros for the time-ordered insert queue. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_INSERT_QUEUE_UNIT_DEFINES_SVH
`define TIME_ORDERED_INSERT_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, checked at every edge outside reset.
`define TOTIQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("totiq: assertion failed");

// Same-cycle implication.
`define TOTIQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("totiq: implication failed");

// Next-cycle implication.
`define TOTIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("totiq: next-cycle implication failed");

`else

`define TOTIQ_ASSERT(lbl, clk, rstn, prop)
`define TOTIQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define TOTIQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- hdl/totiq_pkg.sv -----
// ----------------------------------------------------------------------------
// totiq_pkg
// Types, sizes and codes shared by the time-ordered insert queue.
// ----------------------------------------------------------------------------
package totiq_pkg;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned IDX_W    = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned TIME_W   = 48;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SLACK_W  = 16;
  localparam int unsigned OCC_W    = 7;
  localparam int unsigned STATUS_W = 2;

  localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd1000;

  typedef logic [TIME_W-1:0]   tstamp_t;
  typedef logic [TIME_W:0]     target_t;
  typedef logic [HANDLE_W-1:0] handle_t;
  typedef logic [SLACK_W-1:0]  slack_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;

  typedef enum logic {
    ACT_INSERT  = 1'b0,
    ACT_DEQUEUE = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller state, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CMP  = 6'b000010,
    S_POS  = 6'b000100,
    S_INS  = 6'b001000,
    S_DEQ  = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

  // Controller -> datapath.
  typedef struct packed {
    logic capture;
    logic compare;
    logic find;
    logic insert;
    logic dequeue;
    logic load_out;
  } cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic ins_ok;
    logic deq_ok;
    logic full;
    logic empty;
  } stat_t;

endpackage

// ----- hdl/totiq_req_if.sv -----
// ----------------------------------------------------------------------------
// totiq_req_if
// Request channel: one word carries an insert or a dequeue request.
// ----------------------------------------------------------------------------
interface totiq_req_if;

  logic                valid;
  logic                ready;
  logic                action;
  totiq_pkg::tstamp_t  entry_time;
  totiq_pkg::handle_t  payload_handle;

  modport source (
    output valid,
    output action,
    output entry_time,
    output payload_handle,
    input  ready
  );

  modport sink (
    input  valid,
    input  action,
    input  entry_time,
    input  payload_handle,
    output ready
  );

endinterface

// ----- hdl/totiq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// totiq_rsp_if
// Response channel: one word per request, status plus removed entry.
// ----------------------------------------------------------------------------
interface totiq_rsp_if;

  logic                               valid;
  logic                               ready;
  logic [totiq_pkg::STATUS_W-1:0]     status;
  totiq_pkg::handle_t                 out_handle;
  totiq_pkg::tstamp_t                 out_time;
  totiq_pkg::occ_t                    occupancy;

  modport source (
    output valid,
    output status,
    output out_handle,
    output out_time,
    output occupancy,
    input  ready
  );

  modport sink (
    input  valid,
    input  status,
    input  out_handle,
    input  out_time,
    input  occupancy,
    output ready
  );

endinterface

// ----- hdl/time_ordered_insert_queue_unit.sv -----
// ----------------------------------------------------------------------------
// time_ordered_insert_queue_unit
// Time-ordered insert queue of payload handles keyed by completion time.
// ----------------------------------------------------------------------------
// Holds up to DEPTH (64) entries of {48-bit time, 32-bit handle} in a row
// of register cells, head at cell 0. An insert word forms the target
// entry_time + slack_ns (49 bits, no wrap), places the entry right after
// the last entry whose time is at most the target, or at the head when none
// qualifies. A dequeue word removes and returns the head entry. Every
// request word yields exactly one response word; a full-queue insert
// returns status 1 and an empty-queue dequeue status 2, both with the
// state unchanged and zero handle/time. Occupancy is the count after the
// operation. Timing: one request at a time, sequenced by the controller.
// From acceptance to the response register an insert passes capture,
// parallel compare of all cells, position encode, shift and load; a
// dequeue passes capture, shift and load, and a refused request capture
// and load. The next request is accepted the cycle after the response is
// loaded. The response register frees the request side: a new request is
// taken while an earlier response still waits, and only the final load
// stalls on a busy response port. There is no clearing pass after reset.
// slack_ns resets to 1000; write it only while idle, not enforced here.
// ----------------------------------------------------------------------------
`include "time_ordered_insert_queue_unit_defines.svh"

module time_ordered_insert_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  totiq_pkg::slack_t cfg_wdata_i,
  totiq_req_if.sink         req_i,
  totiq_rsp_if.source       rsp_o
);
  import totiq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] status;
  handle_t             out_handle;
  tstamp_t             out_time;
  occ_t                occupancy;

  // Sequencer
  totiq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Cells, compare, shift and response register
  totiq_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (req_i.action),
    .entry_time_i     (req_i.entry_time),
    .payload_handle_i (req_i.payload_handle),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status),
    .out_handle_o     (out_handle),
    .out_time_o       (out_time),
    .occupancy_o      (occupancy)
  );

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = out_valid;
  assign rsp_o.status     = status;
  assign rsp_o.out_handle = out_handle;
  assign rsp_o.out_time   = out_time;
  assign rsp_o.occupancy  = occupancy;

  // Count can never read both full and empty.
  `TOTIQ_ASSERT(a_full_empty_excl, clk_i, rst_ni, !(stat.full && stat.empty))

  // One request in flight: after a word is taken, the request side closes.
  `TOTIQ_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)

  // A refused insert carries no entry.
  `TOTIQ_ASSERT_IMPL(a_full_no_entry, clk_i, rst_ni,
    rsp_o.valid && (rsp_o.status == ST_FULL),
    (rsp_o.out_handle == '0) && (rsp_o.out_time == '0))

  // An empty-queue dequeue reports an empty queue.
  `TOTIQ_ASSERT_IMPL(a_empty_occ, clk_i, rst_ni,
    rsp_o.valid && (rsp_o.status == ST_EMPTY),
    rsp_o.occupancy == '0)

endmodule

// ----- hdl/totiq_dp.sv -----
// ----------------------------------------------------------------------------
// totiq_dp
// Datapath: slack register, entry cells with per-cell compare, position
// encoder, shift network and response register.
// ----------------------------------------------------------------------------
module totiq_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  totiq_pkg::slack_t              cfg_wdata_i,
  input  logic                           action_i,
  input  totiq_pkg::tstamp_t             entry_time_i,
  input  totiq_pkg::handle_t             payload_handle_i,
  input  totiq_pkg::cmd_t                cmd_i,
  output totiq_pkg::stat_t               stat_o,
  output logic [totiq_pkg::STATUS_W-1:0] status_o,
  output totiq_pkg::handle_t             out_handle_o,
  output totiq_pkg::tstamp_t             out_time_o,
  output totiq_pkg::occ_t                occupancy_o
);
  import totiq_pkg::*;

  slack_t  slack_q;
  cnt_t    count_q, count_d;

  tstamp_t etime_q;
  handle_t handle_q;
  target_t target_q;
  status_e code_q;

  tstamp_t cell_time_q   [DEPTH];
  handle_t cell_handle_q [DEPTH];
  logic [DEPTH-1:0] match_q;

  idx_t    pos_c, pos_q;

  handle_t res_handle_q;
  tstamp_t res_time_q;

  status_e out_status_q;
  handle_t out_handle_q;
  tstamp_t out_time_q;
  occ_t    out_occ_q;

  logic full, empty;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  assign stat_o.full   = full;
  assign stat_o.empty  = empty;
  assign stat_o.ins_ok = (action_i == ACT_INSERT) && !full;
  assign stat_o.deq_ok = (action_i == ACT_DEQUEUE) && !empty;

  // Slack register and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slack_q <= SLACK_RESET;
      count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        slack_q <= cfg_wdata_i;
      end
      count_q <= count_d;
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dequeue) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Request capture; target is one bit wider so it never wraps
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      etime_q  <= entry_time_i;
      handle_q <= payload_handle_i;
      target_q <= (TIME_W+1)'(entry_time_i) + (TIME_W+1)'(slack_q);
      if ((action_i == ACT_INSERT) && full) begin
        code_q <= ST_FULL;
      end else if ((action_i == ACT_DEQUEUE) && empty) begin
        code_q <= ST_EMPTY;
      end else begin
        code_q <= ST_DONE;
      end
    end
  end

  // Insert position: one past the last qualifying entry, head if none
  always_comb begin
    pos_c = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match_q[i]) begin
        pos_c = IDX_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      pos_q <= pos_c;
    end
  end

  // Entry cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam idx_t GIDX = IDX_W'(g);
    tstamp_t below_time, above_time;
    handle_t below_handle, above_handle;

    if (g == 0) begin : g_first
      assign below_time   = '0;
      assign below_handle = '0;
    end else begin : g_below
      assign below_time   = cell_time_q[g-1];
      assign below_handle = cell_handle_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign above_time   = cell_time_q[g];
      assign above_handle = cell_handle_q[g];
    end else begin : g_above
      assign above_time   = cell_time_q[g+1];
      assign above_handle = cell_handle_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.compare) begin
        match_q[g] <= (CNT_W'(g) < count_q) && ((TIME_W+1)'(cell_time_q[g]) <= target_q);
      end
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.insert) begin
        if (GIDX == pos_q) begin
          cell_time_q[g]   <= etime_q;
          cell_handle_q[g] <= handle_q;
        end else if (GIDX > pos_q) begin
          cell_time_q[g]   <= below_time;
          cell_handle_q[g] <= below_handle;
        end
      end else if (cmd_i.dequeue) begin
        cell_time_q[g]   <= above_time;
        cell_handle_q[g] <= above_handle;
      end
    end
  end

  // Removed entry, zero unless a dequeue went through
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_handle_q <= '0;
      res_time_q   <= '0;
    end else if (cmd_i.dequeue) begin
      res_handle_q <= cell_handle_q[0];
      res_time_q   <= cell_time_q[0];
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= code_q;
      out_handle_q <= res_handle_q;
      out_time_q   <= res_time_q;
      out_occ_q    <= OCC_W'(count_q);
    end
  end

  assign status_o     = out_status_q;
  assign out_handle_o = out_handle_q;
  assign out_time_o   = out_time_q;
  assign occupancy_o  = out_occ_q;

endmodule

// ----- hdl/totiq_ctrl.sv -----
// ----------------------------------------------------------------------------
// totiq_ctrl
// Controller: sequences one request at a time and owns the response
// valid flag.
// ----------------------------------------------------------------------------
module totiq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  totiq_pkg::stat_t stat_i,
  output totiq_pkg::cmd_t  cmd_o
);
  import totiq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.ins_ok) begin
            state_d = S_CMP;
          end else if (stat_i.deq_ok) begin
            state_d = S_DEQ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = S_POS;
      end
      S_POS: begin
        cmd_o.find = 1'b1;
        state_d    = S_INS;
      end
      S_INS: begin
        cmd_o.insert = 1'b1;
        state_d      = S_DONE;
      end
      S_DEQ: begin
        cmd_o.dequeue = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- verif/totiq_order_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// totiq_order_checker
// Watches the request, response and slack ports of the time-ordered insert
// queue. It keeps its own copy of the queue, predicts one response word per
// accepted request word and compares it field by field with the response.
// ----------------------------------------------------------------------------
module totiq_order_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  totiq_pkg::slack_t cfg_wdata_i,
  totiq_req_if              req_mon,
  totiq_rsp_if              rsp_mon,
  output int unsigned       err_cnt_o,
  output int unsigned       open_cnt_o
);
  import totiq_pkg::*;

  typedef struct packed {
    status_e status;
    handle_t handle;
    tstamp_t etime;
    occ_t    occ;
  } rsp_word_t;

  // Mirror of the queue, head at index 0.
  tstamp_t     mirror_time   [DEPTH];
  handle_t     mirror_handle [DEPTH];
  int unsigned mirror_count;
  slack_t      mirror_slack;

  rsp_word_t   awaited_rsp_q [$];
  int unsigned mism;

  function automatic rsp_word_t queue_op(input logic act, input tstamp_t et,
                                         input handle_t hd);
    target_t     tgt;
    int unsigned pos;
    int unsigned k;
    bit          hit;
    rsp_word_t   r;
    r = '{status: ST_DONE, handle: '0, etime: '0, occ: '0};
    if (act == ACT_INSERT) begin
      if (mirror_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // 49-bit target, so a time near the top never wraps to a small value
        tgt = {1'b0, et} + target_t'(mirror_slack);
        pos = 0;
        hit = 1'b0;
        for (k = mirror_count; k > 0; k--) begin
          if (!hit && target_t'(mirror_time[k-1]) <= tgt) begin
            pos = k;
            hit = 1'b1;
          end
        end
        for (k = mirror_count; k > pos; k--) begin
          mirror_time[k]   = mirror_time[k-1];
          mirror_handle[k] = mirror_handle[k-1];
        end
        mirror_time[pos]   = et;
        mirror_handle[pos] = hd;
        mirror_count++;
      end
    end else begin
      if (mirror_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.handle = mirror_handle[0];
        r.etime  = mirror_time[0];
        for (k = 1; k < mirror_count; k++) begin
          mirror_time[k-1]   = mirror_time[k];
          mirror_handle[k-1] = mirror_handle[k];
        end
        mirror_count--;
      end
    end
    r.occ = occ_t'(mirror_count);
    return r;
  endfunction

  task automatic report(input string field, input logic [63:0] exp_v,
                        input logic [63:0] act_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
    mism++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_word_t exp_w;
    if (!rst_ni) begin
      mirror_count = 0;
      mirror_slack = SLACK_RESET;
      awaited_rsp_q.delete();
      mism = 0;
    end else begin
      // response first: a word leaving now belongs to an earlier request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_rsp_q.size() == 0) begin
          report("unrequested word, status", 64'hx, 64'(rsp_mon.status));
        end else begin
          exp_w = awaited_rsp_q.pop_front();
          if (rsp_mon.status !== exp_w.status)
            report("status", 64'(exp_w.status), 64'(rsp_mon.status));
          if (rsp_mon.out_handle !== exp_w.handle)
            report("out_handle", 64'(exp_w.handle), 64'(rsp_mon.out_handle));
          if (rsp_mon.out_time !== exp_w.etime)
            report("out_time", 64'(exp_w.etime), 64'(rsp_mon.out_time));
          if (rsp_mon.occupancy !== exp_w.occ)
            report("occupancy", 64'(exp_w.occ), 64'(rsp_mon.occupancy));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        awaited_rsp_q.push_back(queue_op(req_mon.action, req_mon.entry_time,
                                         req_mon.payload_handle));
      end
      if (cfg_we_i) begin
        mirror_slack = cfg_wdata_i;
      end
    end
    err_cnt_o  <= mism;
    open_cnt_o <= awaited_rsp_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the time-ordered insert queue. A short directed
// run, then random phases under several slack values and idle patterns, and
// a back-pressure phase that fills the queue to its refusal point and
// empties it past its empty point. Checking lives in totiq_order_checker.
// ----------------------------------------------------------------------------
module tb_top;

  import totiq_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 500_000;
  localparam int unsigned SETTLE_CYCLES = 12;   // quiet time before a slack write
  localparam int unsigned HOLD_CYCLES   = 400;  // long receiver hold-off
  localparam tstamp_t     TIME_MAX      = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  slack_t      cfg_wdata;
  int unsigned err_cnt;
  int unsigned open_cnt;
  int unsigned cycle_cnt;

  // Idle controls, written only by the stimulus process.
  int unsigned idle_pct;
  int unsigned stall_pct;
  // Hold-off request: the stimulus bumps the sequence, the receiver process
  // notices the change and does the long hold on its own.
  int unsigned hold_req_seq;
  int unsigned hold_seen_seq;

  totiq_req_if req_if ();
  totiq_rsp_if rsp_if ();

  time_ordered_insert_queue_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  totiq_order_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .err_cnt_o   (err_cnt),
    .open_cnt_o  (open_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t: run limit reached, %0d words still open", $time, open_cnt);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Response side: random stalls, or one long hold-off when asked.
  initial begin : rsp_side
    rsp_if.ready  = 1'b0;
    hold_seen_seq = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen_seq != hold_req_seq) begin
        hold_seen_seq = hold_req_seq;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Offer one request word and return at the edge that accepts it. Valid
  // stays high into the next word unless that word starts with idle cycles.
  task automatic push_word(input action_e act, input tstamp_t et, input handle_t hd);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.action         <= act;
    req_if.entry_time     <= et;
    req_if.payload_handle <= hd;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  // Stop offering, wait for every outstanding response, then let the block
  // go quiet before anything touches the slack register. The open count
  // is registered in the checker, so it is read only from the next edge on.
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_slack(input slack_t v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Mostly times clustered near a drifting base so the slack decides the
  // slot; a few extremes and full-width values to toggle every bit.
  function automatic tstamp_t pick_time(input tstamp_t base, input int unsigned span);
    int unsigned r;
    tstamp_t     t;
    r = $urandom_range(0, 99);
    if (r < 4)       t = '0;
    else if (r < 8)  t = TIME_MAX - tstamp_t'($urandom_range(0, 2000));
    else if (r < 18) t = tstamp_t'({$urandom, $urandom});
    else             t = base + tstamp_t'($urandom_range(0, span));
    return t;
  endfunction

  // Random phase: bursts of 40 words, each burst biased toward filling,
  // churning or draining so that both the full and the empty cases recur.
  task automatic random_phase(input int unsigned words, input slack_t slack,
                              input int unsigned idle, input int unsigned stall);
    tstamp_t     base;
    int unsigned n;
    int unsigned ins_pct;
    int unsigned span;
    action_e     act;
    load_slack(slack);
    idle_pct  = idle;
    stall_pct = stall;
    base      = tstamp_t'({$urandom_range(0, 32767), $urandom});
    span      = 2 * int'(slack) + 4000;
    ins_pct   = 90;
    for (n = 0; n < words; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 90;
          1:       ins_pct = 55;
          default: ins_pct = 15;
        endcase
      end
      base += tstamp_t'($urandom_range(0, 300));
      if ($urandom_range(0, 99) < ins_pct) act = ACT_INSERT;
      else                                 act = ACT_DEQUEUE;
      push_word(act, pick_time(base, span), $urandom);
    end
    settle();
  endtask

  initial begin : stimulus
    tstamp_t     base;
    int unsigned n;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    req_if.valid          = 1'b0;
    req_if.action         = ACT_INSERT;
    req_if.entry_time     = '0;
    req_if.payload_handle = '0;
    idle_pct              = 0;
    stall_pct             = 0;
    hold_req_seq          = 0;
    rst_ni                = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset slack of 1000.
    push_word(ACT_DEQUEUE, 48'd77, 32'h1234_5678);       // dequeue on empty
    push_word(ACT_INSERT,  48'd20000, 32'hA5A5_0001);
    push_word(ACT_INSERT,  48'd10000, 32'hA5A5_0002);     // nothing fits: head
    push_word(ACT_INSERT,  48'd20000, 32'hA5A5_0003);     // equal time: behind
    push_word(ACT_INSERT,  48'd0, 32'h0000_0000);         // all-zero fields
    push_word(ACT_INSERT,  TIME_MAX, 32'hFFFF_FFFF);      // all-one fields
    push_word(ACT_INSERT,  TIME_MAX - 48'd500, 32'h0BAD_F00D); // target past 48 bits
    push_word(ACT_INSERT,  48'd19000, 32'hA5A5_0004);     // target lands on an equal time
    push_word(ACT_INSERT,  48'd9500, 32'hA5A5_0005);      // inside slack of the 10000 entry
    repeat (9) push_word(ACT_DEQUEUE, '0, '0);            // drain, last one on empty
    push_word(ACT_INSERT,  48'h5555_5555_5555, 32'h5555_5555);
    push_word(ACT_INSERT,  48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    push_word(ACT_DEQUEUE, 48'hFFFF_0000_FFFF, 32'hFFFF_FFFF);
    push_word(ACT_DEQUEUE, '0, '0);
    settle();

    // Random phases under the slack extremes and the idle patterns.
    random_phase(180, 16'd0,     0,  0);
    random_phase(180, 16'hFFFF,  86, 0);
    random_phase(180, slack_t'($urandom_range(2, 65534)), 0, 86);
    random_phase(180, 16'd1,     22, 22);

    // Back-pressure: the receiver holds off while inserts keep coming, so
    // the block backs up and stalls its request side; enough inserts follow
    // to run past full. After a full drain, dequeues run past empty.
    load_slack(SLACK_RESET);
    idle_pct  = 0;
    stall_pct = 0;
    base      = tstamp_t'({$urandom_range(0, 32767), $urandom});
    hold_req_seq = hold_req_seq + 1;
    for (n = 0; n < DEPTH + 8; n++) begin
      base += tstamp_t'($urandom_range(0, 400));
      push_word(ACT_INSERT, base + tstamp_t'($urandom_range(0, 3000)), $urandom);
    end
    settle();
    stall_pct = 30;
    for (n = 0; n < DEPTH + 4; n++) begin
      push_word(ACT_DEQUEUE, tstamp_t'({$urandom, $urandom}), $urandom);
    end
    settle();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/totiq_pkg.sv
hdl/totiq_req_if.sv
hdl/totiq_rsp_if.sv
hdl/totiq_dp.sv
hdl/totiq_ctrl.sv
hdl/time_ordered_insert_queue_unit.sv
verif/totiq_order_checker.sv
verif/tb_top.sv
